@@ src/psg_three_voice_sound_generator_top_macros.svh @@
// Assertion macros for the three-voice sound generator.
// Included by the top level; no other dependencies.
`ifndef PSG_THREE_VOICE_SOUND_GENERATOR_TOP_MACROS_SVH
`define PSG_THREE_VOICE_SOUND_GENERATOR_TOP_MACROS_SVH

// condition in one cycle implies consequence in the next
`define PSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psg: next-cycle check failed");

// invariant at every clock edge out of reset
`define PSG_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("psg: invariant check failed");

`endif

@@ src/psg_pkg.sv @@
// Shared types and constants of the three-voice sound generator.
// No dependencies; used by the interfaces, the envelope unit and the top level.
package psg_pkg;

    typedef logic [3:0] t_reg_addr;
    typedef logic [7:0] t_reg_data;
    typedef logic [4:0] t_level;
    typedef logic [3:0] t_shape;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam t_reg_addr ADDR_TONE_A_LO = 4'd0;
    localparam t_reg_addr ADDR_TONE_A_HI = 4'd1;
    localparam t_reg_addr ADDR_TONE_B_LO = 4'd2;
    localparam t_reg_addr ADDR_TONE_B_HI = 4'd3;
    localparam t_reg_addr ADDR_TONE_C_LO = 4'd4;
    localparam t_reg_addr ADDR_TONE_C_HI = 4'd5;
    localparam t_reg_addr ADDR_NOISE     = 4'd6;
    localparam t_reg_addr ADDR_MIXER     = 4'd7;
    localparam t_reg_addr ADDR_VOL_A     = 4'd8;
    localparam t_reg_addr ADDR_VOL_B     = 4'd9;
    localparam t_reg_addr ADDR_VOL_C     = 4'd10;
    localparam t_reg_addr ADDR_ENV_LO    = 4'd11;
    localparam t_reg_addr ADDR_ENV_HI    = 4'd12;
    localparam t_reg_addr ADDR_ENV_SHAPE = 4'd13;

    localparam t_level LEVEL_TOP = 5'h1F;

    typedef struct packed {
        logic      tick;
        logic      wr_period_lo;
        logic      wr_period_hi;
        logic      wr_shape;
        t_reg_data data;
    } t_env_ctl;

endpackage

@@ src/psg_ifs.sv @@
// Valid/ready channel interfaces: command transactions in, level transactions out.
// Depends on psg_pkg.
interface psg_cmd_if
    import psg_pkg::*;
();
    logic      valid;
    logic      ready;
    logic      command;
    t_reg_addr reg_addr;
    t_reg_data reg_data;

    modport source (output valid, output command, output reg_addr, output reg_data,
                    input ready);
    modport sink   (input valid, input command, input reg_addr, input reg_data,
                    output ready);
endinterface

interface psg_lvl_if
    import psg_pkg::*;
();
    logic   valid;
    logic   ready;
    t_level level_a;
    t_level level_b;
    t_level level_c;

    modport source (output valid, output level_a, output level_b, output level_c,
                    input ready);
    modport sink   (input valid, input level_a, input level_b, input level_c,
                    output ready);
endinterface

@@ src/psg_env.sv @@
// Envelope generator: period, shape, two-segment level stepping.
// Depends on psg_pkg; the next level is given out for the result register.
module psg_env
    import psg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_env_ctl i_ctl,
    output t_level   o_level_next
);

    logic [15:0] r_period, n_period;
    logic [15:0] r_count,  n_count;
    t_shape      r_shape,  n_shape;
    logic        r_seg,    n_seg;
    t_level      r_level,  n_level;

    // start level per shape and segment
    function automatic t_level env_start(input t_shape shape, input logic seg);
        t_level lvl;
        if (!seg) begin
            lvl = shape[2] ? 5'd0 : LEVEL_TOP;
        end else begin
            unique case (shape)
                4'd8, 4'd11, 4'd13, 4'd14: lvl = LEVEL_TOP;
                default:                   lvl = 5'd0;
            endcase
        end
        return lvl;
    endfunction

    // step per shape and segment, as a 6-bit two's complement delta
    function automatic logic [5:0] env_step(input t_shape shape, input logic seg);
        logic [5:0] d;
        if (!seg) begin
            d = shape[2] ? 6'd1 : 6'h3F;
        end else begin
            unique case (shape)
                4'd8, 4'd14: d = 6'h3F;
                4'd10, 4'd12: d = 6'd1;
                default:      d = 6'd0;
            endcase
        end
        return d;
    endfunction

    logic [16:0] w_next;
    logic [15:0] w_p;
    logic [5:0]  w_lvl;

    always_comb begin
        n_period = r_period;
        n_count  = r_count;
        n_shape  = r_shape;
        n_seg    = r_seg;
        n_level  = r_level;
        w_next   = {1'b0, r_count} + 17'd1;
        w_lvl    = {1'b0, r_level} + env_step(r_shape, r_seg);
        w_p      = r_period;
        if (i_ctl.wr_period_lo) begin
            w_p      = {r_period[15:8], i_ctl.data};
            n_period = w_p | {15'd0, (w_p == 16'd0)};
        end
        if (i_ctl.wr_period_hi) begin
            w_p      = {i_ctl.data, r_period[7:0]};
            n_period = w_p | {15'd0, (w_p == 16'd0)};
        end
        if (i_ctl.wr_shape) begin
            n_shape = i_ctl.data[3:0];
            n_count = 16'd0;
            n_seg   = 1'b0;
            n_level = env_start(i_ctl.data[3:0], 1'b0);
        end
        if (i_ctl.tick) begin
            if (w_next >= {1'b0, r_period}) begin
                n_count = 16'd0;
                if (w_lvl[5]) begin
                    n_seg   = ~r_seg;
                    n_level = env_start(r_shape, ~r_seg);
                end else begin
                    n_level = w_lvl[4:0];
                end
            end else begin
                n_count = w_next[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 16'd1;
            r_count  <= 16'd0;
            r_shape  <= 4'd0;
            r_seg    <= 1'b0;
            r_level  <= LEVEL_TOP;
        end else begin
            r_period <= n_period;
            r_count  <= n_count;
            r_shape  <= n_shape;
            r_seg    <= n_seg;
            r_level  <= n_level;
        end
    end

    assign o_level_next = n_level;

endmodule

@@ src/psg_three_voice_sound_generator_top.sv @@
// Top level of the three-voice sound generator: input register, tone, noise,
// mixer and volume state, result register. Depends on psg_pkg, psg_ifs, psg_env.
//
//   channel   dir   modport  carries
//   i_cmd     in    sink     command, reg_addr, reg_data
//   o_lvl     out   source   level_a, level_b, level_c (ticks only)
//
// One transaction per cycle sustained while o_lvl is not stalled. A tick passes
// through the input register, and its levels are then held in the result register.
// Register writes give no output transaction. Synchronous active-low reset
// restores all generator state. While o_lvl is stalled a tick waits in the input
// register and i_cmd.ready drops only if that register cannot drain.
`include "psg_three_voice_sound_generator_top_macros.svh"

module psg_three_voice_sound_generator_top
    import psg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    psg_cmd_if.sink   i_cmd,
    psg_lvl_if.source o_lvl
);

    // input register
    logic      r_in_valid;
    logic      r_cmd;
    t_reg_addr r_addr;
    t_reg_data r_data;

    // generator state
    logic [11:0] r_tone_period [3];
    logic [11:0] n_tone_period [3];
    logic [11:0] r_tone_count  [3];
    logic [11:0] n_tone_count  [3];
    logic [2:0]  r_tone_bit,    n_tone_bit;
    logic [2:0]  r_tone_off,    n_tone_off;
    logic [2:0]  r_noise_off,   n_noise_off;
    logic [3:0]  r_vol [3];
    logic [3:0]  n_vol [3];
    logic [2:0]  r_use_env,     n_use_env;
    logic [4:0]  r_noise_period, n_noise_period;
    logic [5:0]  r_noise_count,  n_noise_count;
    logic [16:0] r_noise_lfsr,   n_noise_lfsr;

    // result register
    logic   r_out_valid;
    t_level r_out [3];
    t_level n_out [3];

    logic     w_out_free, w_adv, w_tick, w_wr;
    logic     w_gate;
    logic [1:0] w_ch;
    logic [11:0] w_tp;
    logic [12:0] w_tnext;
    logic [6:0]  w_nnext;
    t_env_ctl w_env_ctl;
    t_level   w_env_level;

    assign w_out_free  = !r_out_valid || o_lvl.ready;
    assign w_adv       = r_in_valid && ((r_cmd == CMD_WRITE) || w_out_free);
    assign w_tick      = w_adv && (r_cmd == CMD_TICK);
    assign w_wr        = w_adv && (r_cmd == CMD_WRITE);
    assign i_cmd.ready = !r_in_valid || w_adv;

    always_comb begin
        w_env_ctl.tick         = w_tick;
        w_env_ctl.wr_period_lo = w_wr && (r_addr == ADDR_ENV_LO);
        w_env_ctl.wr_period_hi = w_wr && (r_addr == ADDR_ENV_HI);
        w_env_ctl.wr_shape     = w_wr && (r_addr == ADDR_ENV_SHAPE);
        w_env_ctl.data         = r_data;
    end

    psg_env u_env (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_env_ctl),
        .o_level_next (w_env_level)
    );

    always_comb begin
        n_tone_period  = r_tone_period;
        n_tone_count   = r_tone_count;
        n_tone_bit     = r_tone_bit;
        n_tone_off     = r_tone_off;
        n_noise_off    = r_noise_off;
        n_vol          = r_vol;
        n_use_env      = r_use_env;
        n_noise_period = r_noise_period;
        n_noise_count  = r_noise_count;
        n_noise_lfsr   = r_noise_lfsr;
        n_out          = r_out;
        w_ch           = r_addr[2:1];
        w_tp           = 12'd0;
        w_tnext        = 13'd0;
        w_gate         = 1'b0;
        w_nnext        = {1'b0, r_noise_count} + 7'd1;

        if (w_wr) begin
            unique case (r_addr)
                ADDR_TONE_A_LO, ADDR_TONE_B_LO, ADDR_TONE_C_LO: begin
                    w_tp = {r_tone_period[w_ch][11:8], r_data};
                    n_tone_period[w_ch] = w_tp | {11'd0, (w_tp == 12'd0)};
                end
                ADDR_TONE_A_HI, ADDR_TONE_B_HI, ADDR_TONE_C_HI: begin
                    w_tp = {r_data[3:0], r_tone_period[w_ch][7:0]};
                    n_tone_period[w_ch] = w_tp | {11'd0, (w_tp == 12'd0)};
                end
                ADDR_NOISE: begin
                    n_noise_period = r_data[4:0] | {4'd0, (r_data[4:0] == 5'd0)};
                end
                ADDR_MIXER: begin
                    n_tone_off  = r_data[2:0];
                    n_noise_off = r_data[5:3];
                end
                ADDR_VOL_A, ADDR_VOL_B, ADDR_VOL_C: begin
                    w_ch = 2'(r_addr - ADDR_VOL_A);
                    n_vol[w_ch]     = r_data[3:0];
                    n_use_env[w_ch] = r_data[4];
                end
                default: begin
                end
            endcase
        end

        if (w_tick) begin
            if (w_nnext >= {1'b0, r_noise_period, 1'b0}) begin
                n_noise_count = 6'd0;
                n_noise_lfsr  = {r_noise_lfsr[0] ^ r_noise_lfsr[3], r_noise_lfsr[16:1]};
            end else begin
                n_noise_count = w_nnext[5:0];
            end
            for (int ch = 0; ch < 3; ch++) begin
                w_tnext = {1'b0, r_tone_count[ch]} + 13'd1;
                if (w_tnext >= {1'b0, r_tone_period[ch]}) begin
                    n_tone_count[ch] = 12'd0;
                    n_tone_bit[ch]   = ~r_tone_bit[ch];
                end else begin
                    n_tone_count[ch] = w_tnext[11:0];
                end
                w_gate = (n_tone_bit[ch] | r_tone_off[ch])
                       & (n_noise_lfsr[0] | r_noise_off[ch]);
                if (!w_gate) begin
                    n_out[ch] = 5'd0;
                end else if (r_use_env[ch]) begin
                    n_out[ch] = w_env_level;
                end else begin
                    n_out[ch] = {r_vol[ch], 1'b1};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_tone_bit     <= 3'd0;
            r_tone_off     <= 3'd0;
            r_noise_off    <= 3'd0;
            r_use_env      <= 3'd0;
            r_noise_period <= 5'd1;
            r_noise_count  <= 6'd0;
            r_noise_lfsr   <= 17'd1;
            for (int ch = 0; ch < 3; ch++) begin
                r_tone_period[ch] <= 12'd1;
                r_tone_count[ch]  <= 12'd0;
                r_vol[ch]         <= 4'd0;
            end
        end else begin
            if (i_cmd.ready) begin
                r_in_valid <= i_cmd.valid;
            end
            if (w_tick) begin
                r_out_valid <= 1'b1;
            end else if (o_lvl.ready) begin
                r_out_valid <= 1'b0;
            end
            r_tone_period  <= n_tone_period;
            r_tone_count   <= n_tone_count;
            r_tone_bit     <= n_tone_bit;
            r_tone_off     <= n_tone_off;
            r_noise_off    <= n_noise_off;
            r_vol          <= n_vol;
            r_use_env      <= n_use_env;
            r_noise_period <= n_noise_period;
            r_noise_count  <= n_noise_count;
            r_noise_lfsr   <= n_noise_lfsr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready) begin
            r_cmd  <= i_cmd.command;
            r_addr <= i_cmd.reg_addr;
            r_data <= i_cmd.reg_data;
        end
        r_out <= n_out;
    end

    assign o_lvl.valid   = r_out_valid;
    assign o_lvl.level_a = r_out[0];
    assign o_lvl.level_b = r_out[1];
    assign o_lvl.level_c = r_out[2];

    // a write never produces an output transaction
    `PSG_ASSERT_NEXT(a_write_no_out, i_clk, i_rst_n, r_in_valid && (r_cmd == CMD_WRITE) && !r_out_valid, !r_out_valid)
    // a tick that leaves the input register shows up as an output transaction
    `PSG_ASSERT_NEXT(a_tick_gives_out, i_clk, i_rst_n, w_tick, r_out_valid)
    // the noise register never locks up at zero
    `PSG_ASSERT_ALWAYS(a_lfsr_live, i_clk, i_rst_n, r_noise_lfsr != 17'd0)

endmodule

@@ verif/tb_psg_three_voice_sound_generator_top.sv @@
// Testbench for the three-voice sound generator: directed and random register writes
// and ticks, checked against a cycle-free predictor of the levels each tick produces.
// Depends on psg_pkg, psg_ifs and the top level psg_three_voice_sound_generator_top.
module tb_psg_three_voice_sound_generator_top;
    import psg_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int ITEM_TARGET = 600;

    localparam t_reg_addr ADDR_SPARE_0 = 4'd14;
    localparam t_reg_addr ADDR_SPARE_1 = 4'd15;

    typedef struct {
        logic      drain_wait;
        logic      command;
        t_reg_addr reg_addr;
        t_reg_data reg_data;
    } t_cmd_item;

    typedef struct {
        t_level a;
        t_level b;
        t_level c;
    } t_levels;

    typedef enum logic [1:0] {ENV_HOLD, ENV_UP, ENV_DOWN} t_env_dir;

    typedef struct {
        t_env_dir dir;
        t_level   start;
    } t_env_rule;

    typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} t_rdy_mode;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    psg_cmd_if cmd_if ();
    psg_lvl_if lvl_if ();

    psg_three_voice_sound_generator_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_lvl   (lvl_if)
    );

    // predicted generator state
    logic [11:0] tone_prd      [3];
    logic [11:0] tone_cnt      [3];
    logic        tone_sq       [3];
    logic        mix_tone_off  [3];
    logic        mix_noise_off [3];
    logic [3:0]  ch_vol        [3];
    logic        ch_env_en     [3];
    logic [4:0]  nz_prd;
    logic [5:0]  nz_cnt;
    logic [16:0] nz_lfsr;
    logic [15:0] env_prd;
    logic [15:0] env_cnt;
    t_shape      env_shp;
    logic        env_seg;
    t_level      env_lvl;

    t_cmd_item cmd_backlog [$];
    t_levels   levels_due  [$];

    int        mismatch_cnt = 0;
    int        cycle_cnt = 0;
    int        n_items = 0;
    t_cmd_item drv_item;
    int        burst_left = 0;
    int        gap_left = 0;
    t_rdy_mode rdy_mode = RDY_ALWAYS;
    int        rdy_span = 0;
    int        rdy_phase = 0;
    logic      rdy_next;
    t_levels   mon_exp;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial begin
        cmd_if.valid = 1'b0;
        cmd_if.command = CMD_WRITE;
        cmd_if.reg_addr = '0;
        cmd_if.reg_data = '0;
        lvl_if.ready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // segment 0 is the attack/decay leg; segment 1 follows the first overflow
    function automatic t_env_rule env_rule(input t_shape shp, input logic seg);
        t_env_rule r;
        logic      attack;
        logic      cont;
        logic      alt;
        logic      hold_bit;
        logic      rising;
        attack = shp[2];
        cont = shp[3];
        alt = shp[1];
        hold_bit = shp[0];
        if (!seg) begin
            r.dir = attack ? ENV_UP : ENV_DOWN;
            r.start = attack ? 5'd0 : LEVEL_TOP;
        end else if (!cont || hold_bit) begin
            r.dir = ENV_HOLD;
            r.start = (cont && (attack ^ alt)) ? LEVEL_TOP : 5'd0;
        end else begin
            rising = attack ^ alt;
            r.dir = rising ? ENV_UP : ENV_DOWN;
            r.start = rising ? 5'd0 : LEVEL_TOP;
        end
        return r;
    endfunction

    task automatic predict_levels(input t_cmd_item it);
        int          ch;
        int          idx;
        logic [11:0] prd12;
        logic [15:0] prd16;
        logic [6:0]  nz_next;
        logic [12:0] tone_next;
        logic [16:0] env_next;
        t_env_rule   rule;
        logic        nz_bit;
        logic        gate;
        t_level      lvl_ch [3];
        t_levels     lv;
        if (it.command == CMD_WRITE) begin
            case (it.reg_addr)
                ADDR_TONE_A_LO, ADDR_TONE_B_LO, ADDR_TONE_C_LO: begin
                    idx = int'(it.reg_addr[2:1]);
                    prd12 = {tone_prd[idx][11:8], it.reg_data};
                    tone_prd[idx] = (prd12 == 12'd0) ? 12'd1 : prd12;
                end
                ADDR_TONE_A_HI, ADDR_TONE_B_HI, ADDR_TONE_C_HI: begin
                    idx = int'(it.reg_addr[2:1]);
                    prd12 = {it.reg_data[3:0], tone_prd[idx][7:0]};
                    tone_prd[idx] = (prd12 == 12'd0) ? 12'd1 : prd12;
                end
                ADDR_NOISE: begin
                    nz_prd = (it.reg_data[4:0] == 5'd0) ? 5'd1 : it.reg_data[4:0];
                end
                ADDR_MIXER: begin
                    for (ch = 0; ch < 3; ch++) begin
                        mix_tone_off[ch] = it.reg_data[ch];
                        mix_noise_off[ch] = it.reg_data[ch + 3];
                    end
                end
                ADDR_VOL_A, ADDR_VOL_B, ADDR_VOL_C: begin
                    idx = int'(it.reg_addr - ADDR_VOL_A);
                    ch_vol[idx] = it.reg_data[3:0];
                    ch_env_en[idx] = it.reg_data[4];
                end
                ADDR_ENV_LO: begin
                    prd16 = {env_prd[15:8], it.reg_data};
                    env_prd = (prd16 == 16'd0) ? 16'd1 : prd16;
                end
                ADDR_ENV_HI: begin
                    prd16 = {it.reg_data, env_prd[7:0]};
                    env_prd = (prd16 == 16'd0) ? 16'd1 : prd16;
                end
                ADDR_ENV_SHAPE: begin
                    env_shp = it.reg_data[3:0];
                    env_cnt = '0;
                    env_seg = 1'b0;
                    rule = env_rule(env_shp, 1'b0);
                    env_lvl = rule.start;
                end
                default: begin
                end
            endcase
        end else begin
            nz_next = {1'b0, nz_cnt} + 7'd1;
            if (nz_next >= {1'b0, nz_prd, 1'b0}) begin
                nz_cnt = '0;
                nz_lfsr = {nz_lfsr[0] ^ nz_lfsr[3], nz_lfsr[16:1]};
            end else begin
                nz_cnt = nz_next[5:0];
            end
            env_next = {1'b0, env_cnt} + 17'd1;
            if (env_next >= {1'b0, env_prd}) begin
                env_cnt = '0;
                rule = env_rule(env_shp, env_seg);
                if ((rule.dir == ENV_UP && env_lvl == LEVEL_TOP) ||
                    (rule.dir == ENV_DOWN && env_lvl == 5'd0)) begin
                    env_seg = ~env_seg;
                    rule = env_rule(env_shp, env_seg);
                    env_lvl = rule.start;
                end else if (rule.dir == ENV_UP) begin
                    env_lvl = env_lvl + 5'd1;
                end else if (rule.dir == ENV_DOWN) begin
                    env_lvl = env_lvl - 5'd1;
                end
            end else begin
                env_cnt = env_next[15:0];
            end
            nz_bit = nz_lfsr[0];
            for (ch = 0; ch < 3; ch++) begin
                tone_next = {1'b0, tone_cnt[ch]} + 13'd1;
                if (tone_next >= {1'b0, tone_prd[ch]}) begin
                    tone_cnt[ch] = '0;
                    tone_sq[ch] = ~tone_sq[ch];
                end else begin
                    tone_cnt[ch] = tone_next[11:0];
                end
                gate = (tone_sq[ch] | mix_tone_off[ch]) & (nz_bit | mix_noise_off[ch]);
                if (!gate) begin
                    lvl_ch[ch] = 5'd0;
                end else if (ch_env_en[ch]) begin
                    lvl_ch[ch] = env_lvl;
                end else begin
                    lvl_ch[ch] = {ch_vol[ch], 1'b1};
                end
            end
            lv.a = lvl_ch[0];
            lv.b = lvl_ch[1];
            lv.c = lvl_ch[2];
            levels_due.push_back(lv);
        end
    endtask

    task automatic push_write(input t_reg_addr addr, input t_reg_data data);
        t_cmd_item it;
        it.drain_wait = 1'b0;
        it.command = CMD_WRITE;
        it.reg_addr = addr;
        it.reg_data = data;
        cmd_backlog.push_back(it);
        n_items++;
    endtask

    task automatic push_tick();
        t_cmd_item it;
        it.drain_wait = 1'b0;
        it.command = CMD_TICK;
        it.reg_addr = t_reg_addr'($urandom);
        it.reg_data = t_reg_data'($urandom);
        cmd_backlog.push_back(it);
        n_items++;
    endtask

    task automatic push_drain();
        t_cmd_item it;
        it.drain_wait = 1'b1;
        it.command = CMD_WRITE;
        it.reg_addr = '0;
        it.reg_data = '0;
        cmd_backlog.push_back(it);
    endtask

    task automatic check_level(input string fld, input t_level want, input t_level got);
        if (want !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, fld, want, got);
            mismatch_cnt++;
        end
    endtask

    // driver: bursts of transactions separated by random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                predict_levels(drv_item);
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    cmd_if.valid <= 1'b0;
                end else if (cmd_backlog.size() != 0 && cmd_backlog[0].drain_wait) begin
                    if (levels_due.size() == 0) begin
                        cmd_backlog.delete(0);
                    end
                    cmd_if.valid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    drv_item = cmd_backlog.pop_front();
                    cmd_if.valid <= 1'b1;
                    cmd_if.command <= drv_item.command;
                    cmd_if.reg_addr <= drv_item.reg_addr;
                    cmd_if.reg_data <= drv_item.reg_data;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern changes mode every stretch
    always @(posedge clk) begin
        if (rdy_span == 0) begin
            rdy_span = $urandom_range(16, 160);
            rdy_mode = t_rdy_mode'($urandom_range(0, 3));
        end else begin
            rdy_span--;
        end
        rdy_phase++;
        case (rdy_mode)
            RDY_ALWAYS:   rdy_next = 1'b1;
            RDY_COIN:     rdy_next = 1'($urandom_range(0, 1));
            RDY_SPARSE:   rdy_next = ($urandom_range(0, 5) == 0);
            default:      rdy_next = (rdy_phase % 3 != 0);
        endcase
        lvl_if.ready <= rdy_next;
    end

    always @(posedge clk) begin
        if (rst_n && lvl_if.valid && lvl_if.ready) begin
            if (levels_due.size() == 0) begin
                $display("%0t: levels expected none actual %0d %0d %0d", $time,
                         lvl_if.level_a, lvl_if.level_b, lvl_if.level_c);
                mismatch_cnt++;
            end else begin
                mon_exp = levels_due.pop_front();
                check_level("level_a", mon_exp.a, lvl_if.level_a);
                check_level("level_b", mon_exp.b, lvl_if.level_b);
                check_level("level_c", mon_exp.c, lvl_if.level_c);
            end
        end
    end

    initial begin
        int        ch;
        int        seg;
        int        k;
        int        body_len;
        t_reg_addr tone_lo_addr [3];
        t_reg_addr tone_hi_addr [3];
        t_reg_addr vol_addr     [3];
        t_env_rule rule;

        tone_lo_addr[0] = ADDR_TONE_A_LO;
        tone_lo_addr[1] = ADDR_TONE_B_LO;
        tone_lo_addr[2] = ADDR_TONE_C_LO;
        tone_hi_addr[0] = ADDR_TONE_A_HI;
        tone_hi_addr[1] = ADDR_TONE_B_HI;
        tone_hi_addr[2] = ADDR_TONE_C_HI;
        vol_addr[0] = ADDR_VOL_A;
        vol_addr[1] = ADDR_VOL_B;
        vol_addr[2] = ADDR_VOL_C;

        for (ch = 0; ch < 3; ch++) begin
            tone_prd[ch] = 12'd1;
            tone_cnt[ch] = '0;
            tone_sq[ch] = 1'b0;
            mix_tone_off[ch] = 1'b0;
            mix_noise_off[ch] = 1'b0;
            ch_vol[ch] = '0;
            ch_env_en[ch] = 1'b0;
        end
        nz_prd = 5'd1;
        nz_cnt = '0;
        nz_lfsr = 17'd1;
        env_prd = 16'd1;
        env_cnt = '0;
        env_shp = '0;
        env_seg = 1'b0;
        rule = env_rule(env_shp, 1'b0);
        env_lvl = rule.start;

        // directed: zero periods, ignored bits and addresses, extremes, shrinking period
        push_tick();
        push_write(ADDR_TONE_A_LO, 8'h00);
        push_write(ADDR_TONE_A_HI, 8'hFF);
        push_tick();
        push_write(ADDR_TONE_A_LO, 8'hFF);
        push_write(ADDR_TONE_B_HI, 8'h0A);
        push_write(ADDR_TONE_B_LO, 8'h00);
        push_write(ADDR_TONE_B_HI, 8'hF0);
        push_write(ADDR_NOISE, 8'hE0);
        push_write(ADDR_NOISE, 8'hFF);
        push_write(ADDR_MIXER, 8'hC0);
        push_write(ADDR_VOL_A, 8'hFF);
        push_write(ADDR_VOL_B, 8'hEF);
        push_write(ADDR_VOL_C, 8'h10);
        push_write(ADDR_ENV_HI, 8'hFF);
        push_write(ADDR_ENV_LO, 8'hFF);
        push_write(ADDR_ENV_LO, 8'h00);
        push_write(ADDR_ENV_HI, 8'h00);
        push_write(ADDR_ENV_SHAPE, 8'hF9);
        push_write(ADDR_SPARE_0, 8'hFF);
        push_write(ADDR_SPARE_1, 8'hA5);
        push_write(ADDR_TONE_C_LO, 8'hC8);
        repeat (4) push_tick();
        push_write(ADDR_TONE_C_LO, 8'h02);
        push_tick();
        push_write(ADDR_MIXER, 8'hFF);
        push_tick();
        push_drain();

        // random: setup writes with small periods, then a run of mostly ticks
        seg = 0;
        while (seg < 16 || n_items < ITEM_TARGET) begin
            push_write(ADDR_ENV_HI,
                       ($urandom_range(0, 9) == 0) ? t_reg_data'($urandom) : 8'h00);
            push_write(ADDR_ENV_LO, t_reg_data'($urandom_range(0, 3)));
            push_write(ADDR_ENV_SHAPE, {4'($urandom), 4'(seg)});
            for (ch = 0; ch < 3; ch++) begin
                if ($urandom_range(0, 1) == 1) begin
                    push_write(tone_lo_addr[ch], ($urandom_range(0, 7) == 0) ?
                               t_reg_data'($urandom) : t_reg_data'($urandom_range(0, 24)));
                end
                if ($urandom_range(0, 1) == 1) begin
                    push_write(tone_hi_addr[ch], ($urandom_range(0, 7) == 0) ?
                               t_reg_data'($urandom) : {4'($urandom), 4'h0});
                end
                if ($urandom_range(0, 1) == 1) begin
                    push_write(vol_addr[ch], t_reg_data'($urandom));
                end
            end
            if ($urandom_range(0, 1) == 1) begin
                push_write(ADDR_NOISE, {3'($urandom), 5'($urandom_range(0, 6))});
            end
            if ($urandom_range(0, 1) == 1) begin
                push_write(ADDR_MIXER, t_reg_data'($urandom));
            end
            body_len = $urandom_range(10, 40);
            for (k = 0; k < body_len; k++) begin
                if ($urandom_range(0, 99) < 88) begin
                    push_tick();
                end else begin
                    push_write(t_reg_addr'($urandom_range(0, 15)), t_reg_data'($urandom));
                end
            end
            if (seg % 4 == 3) begin
                push_drain();
            end
            seg++;
        end

        while (cmd_backlog.size() != 0 || cmd_if.valid !== 1'b0) @(posedge clk);
        while (levels_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_cnt == 0 && levels_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
